@@ src/apq_pkg.sv @@
package apq_pkg;

  localparam int VALUE_W = 32;
  localparam int OCC_W   = 3;

  // Input action codes.
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_INSERTED = 2'd0,
    STATUS_OVERFLOW = 2'd1,
    STATUS_REMOVED  = 2'd2,
    STATUS_EMPTY    = 2'd3
  } status_t;

endpackage

@@ src/apq_in_if.sv @@
interface apq_in_if;
  logic                                valid;
  logic                                ready;
  logic                                action;
  logic signed [apq_pkg::VALUE_W-1:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

@@ src/apq_out_if.sv @@
interface apq_out_if;
  logic                                valid;
  logic                                ready;
  apq_pkg::status_t                    status;
  logic signed [apq_pkg::VALUE_W-1:0] removed_value;
  logic        [apq_pkg::OCC_W-1:0]   occupancy;

  modport source (output valid, output status, output removed_value, output occupancy,
                  input ready);
  modport sink   (input valid, input status, input removed_value, input occupancy,
                  output ready);
endinterface

@@ src/ascending_priority_queue.sv @@
// Insert, overflow and empty-remove items: the result is registered at the accept edge
// and shows in the next cycle; the next item can be accepted then if rsp.ready is high.
// Remove: a minimum scan reads slots 0 through tail in turn; each entry behind the
// minimum is then read and written one slot down, and the result is loaded once the
// output register is free. The single read port of the slot memory reads one slot per cycle.
// Synchronous active-high reset empties the queue; slot contents are not cleared.
module ascending_priority_queue #(
  parameter int DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  apq_in_if.sink      req,
  apq_out_if.source   rsp
);

  localparam int IDX_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  // The head slot never moves and always stays empty; stored values live in
  // slots 0 through tail, so the ring never actually wraps.
  localparam logic [IDX_W-1:0] LAST = IDX_W'(DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_SHIFT = 3'b100
  } state_t;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
    return (i == LAST) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
    return (i == '0) ? LAST : i - 1'b1;
  endfunction

  // Occupancy for a given tail, cut or widened to the result field.
  function automatic logic [apq_pkg::OCC_W-1:0] occ_of(input logic [IDX_W-1:0] t);
    logic [IDX_W+apq_pkg::OCC_W-1:0] wide;
    wide = (t == LAST) ? '0 : {{apq_pkg::OCC_W{1'b0}}, t} + 1'b1;
    return wide[apq_pkg::OCC_W-1:0];
  endfunction

  state_t state;
  logic [IDX_W-1:0] tail;

  // Scan bookkeeping: scan_idx is the slot being read, cmp_idx the slot whose
  // data is on the read port this cycle.
  logic [IDX_W-1:0] scan_idx;
  logic             scan_end;
  logic             cmp_valid;
  logic [IDX_W-1:0] cmp_idx;
  logic             best_have;
  logic signed [apq_pkg::VALUE_W-1:0] best_val;
  logic [IDX_W-1:0] best_idx;

  // Shift bookkeeping: sh_rd is the gap whose successor is read; the write of
  // that successor into the gap follows in the next cycle.
  logic [IDX_W-1:0] sh_rd;
  logic             wr_pend;
  logic [IDX_W-1:0] wr_addr;

  // Output register.
  logic                               res_valid;
  apq_pkg::status_t                   res_status;
  logic signed [apq_pkg::VALUE_W-1:0] res_value;
  logic [apq_pkg::OCC_W-1:0]          res_occ;

  logic                               res_free;
  logic                               res_load;
  logic                               accept;
  logic                               is_insert;
  logic [IDX_W-1:0]                   tail_nx;
  logic [IDX_W-1:0]                   tail_dec;
  logic                               full;
  logic                               empty;
  logic                               scan_issue;
  logic                               take;
  logic signed [apq_pkg::VALUE_W-1:0] best_val_upd;
  logic [IDX_W-1:0]                   best_idx_upd;
  logic                               scan_last;
  logic                               sh_step;
  logic                               finish;

  logic                               mem_we;
  logic [IDX_W-1:0]                   mem_waddr;
  logic signed [apq_pkg::VALUE_W-1:0] mem_wdata;
  logic [IDX_W-1:0]                   mem_raddr;
  logic signed [apq_pkg::VALUE_W-1:0] mem_rdata;

  assign res_free  = !res_valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && res_free;
  assign accept    = req.valid && req.ready;
  assign is_insert = (req.action == apq_pkg::ACT_INSERT);

  assign tail_nx  = ring_next(tail);
  assign tail_dec = ring_prev(tail);
  assign full     = (tail_nx == LAST);
  assign empty    = (tail == LAST);

  // The scan comparator: strict less-than keeps the earliest of equal values.
  assign scan_issue   = (state == S_SCAN) && !scan_end;
  assign take         = cmp_valid && (!best_have || (mem_rdata < best_val));
  assign best_val_upd = take ? mem_rdata : best_val;
  assign best_idx_upd = take ? cmp_idx : best_idx;
  assign scan_last    = (state == S_SCAN) && cmp_valid && (cmp_idx == tail);

  assign sh_step = (state == S_SHIFT) && (sh_rd != tail);
  assign finish  = (state == S_SHIFT) && (sh_rd == tail) && !wr_pend && res_free;

  // A result is loaded at once for inserts and empty removes, and at the end
  // of the shift for a real remove.
  assign res_load = (accept && (is_insert || empty)) || finish;

  assign mem_raddr = (state == S_SCAN) ? scan_idx : ring_next(sh_rd);
  assign mem_we    = (accept && is_insert && !full) || ((state == S_SHIFT) && wr_pend);
  assign mem_waddr = (state == S_SHIFT) ? wr_addr : tail_nx;
  assign mem_wdata = (state == S_SHIFT) ? mem_rdata : req.value;

  apq_mem #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tail      <= LAST;
      res_valid <= 1'b0;
      scan_end  <= 1'b0;
      cmp_valid <= 1'b0;
      best_have <= 1'b0;
      wr_pend   <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (rsp.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (is_insert) begin
              res_value <= '0;
              if (full) begin
                res_status <= apq_pkg::STATUS_OVERFLOW;
                res_occ    <= occ_of(tail);
              end else begin
                res_status <= apq_pkg::STATUS_INSERTED;
                res_occ    <= occ_of(tail_nx);
                tail       <= tail_nx;
              end
            end else if (empty) begin
              res_status <= apq_pkg::STATUS_EMPTY;
              res_value  <= '0;
              res_occ    <= occ_of(tail);
            end else begin
              state     <= S_SCAN;
              scan_idx  <= ring_next(LAST);
              scan_end  <= 1'b0;
              cmp_valid <= 1'b0;
              best_have <= 1'b0;
            end
          end
        end
        S_SCAN: begin
          if (scan_issue) begin
            scan_idx <= ring_next(scan_idx);
            scan_end <= (scan_idx == tail);
            cmp_idx  <= scan_idx;
          end
          cmp_valid <= scan_issue;
          if (cmp_valid) begin
            best_have <= 1'b1;
            best_val  <= best_val_upd;
            best_idx  <= best_idx_upd;
          end
          if (scan_last) begin
            state   <= S_SHIFT;
            sh_rd   <= best_idx_upd;
            wr_pend <= 1'b0;
          end
        end
        S_SHIFT: begin
          wr_pend <= sh_step;
          if (sh_step) begin
            wr_addr <= sh_rd;
            sh_rd   <= ring_next(sh_rd);
          end
          if (finish) begin
            state      <= S_IDLE;
            tail       <= tail_dec;
            res_status <= apq_pkg::STATUS_REMOVED;
            res_value  <= best_val;
            res_occ    <= occ_of(tail_dec);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid         = res_valid;
  assign rsp.status        = res_status;
  assign rsp.removed_value = res_value;
  assign rsp.occupancy     = res_occ;

`ifndef SYNTHESIS
  // The sequencer is in exactly one state at a time.
  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("sequencer state is not one-hot");

  // No item is taken while a remove is still in progress.
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !req.ready)
    else $error("input ready while a remove is in progress");

  // The minimum scan only reads; the slot store is never written during it.
  a_scan_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> !mem_we)
    else $error("slot write during minimum scan");

  // A finished remove steps the tail back by exactly one slot.
  a_tail_step_back: assert property (@(posedge clk) disable iff (rst)
    finish |=> (tail == $past(tail_dec)))
    else $error("tail did not step back after a remove");
`endif

endmodule

@@ src/apq_mem.sv @@
// Slot store: one write port, one read port with registered read data.
module apq_mem #(
  parameter int DEPTH = 8,
  parameter int IDX_W = 3
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic        [IDX_W-1:0]             waddr,
  input  logic signed [apq_pkg::VALUE_W-1:0] wdata,
  input  logic        [IDX_W-1:0]             raddr,
  output logic signed [apq_pkg::VALUE_W-1:0] rdata
);

  logic signed [apq_pkg::VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
